@@ rtl/core/msrt_pkg.sv @@
// Shared types for the multi-slot repeat timer: command codes and the
// packed input and result records. No dependencies.
package msrt_pkg;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  // Most results a single tick reports.
  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [1:0]        command;
    logic [3:0]        slot_id;
    logic signed [7:0] repeat_count;
    logic [31:0]       timeout_ticks;
  } in_t;

  typedef struct packed {
    logic       status;
    logic [3:0] slot;
    logic       fired;
    logic       retired;
    logic [4:0] active_count;
    logic       last;
  } out_t;

endpackage

@@ rtl/core/multi_slot_repeat_timer.sv @@
// Multi-slot repeat timer: slot table in a memory with registered read, valid bits
// in flops, sequential scan for start and tick. Depends on msrt_pkg.
// Restart/cancel go from idle straight to the flush state; start scans for a free
// slot in S_FIND, then flushes; tick walks the table memory one slot per cycle in
// S_EVAL, held while the result register is held by out_ready low, then flushes.
// Throughput: one item at a time; the next transfer is taken after the last result
// is loaded. Reset clears valid bits, clock, counters and handshake; memory is not
// cleared, entries are gated by their valid bits.
module multi_slot_repeat_timer #(
  parameter int NUM_SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  msrt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output msrt_pkg::out_t out_data
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  typedef struct packed {
    logic [31:0]       start;
    logic [31:0]       timeout;
    logic signed [7:0] repeats;
  } slot_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_EVAL,
    S_FLUSH
  } state_t;

  state_t state;

  slot_entry_t mem [NUM_SLOTS];
  slot_entry_t rd_data;
  slot_entry_t wr_data;
  logic        rd_en;
  logic        wr_en;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;

  logic [NUM_SLOTS-1:0] slot_valid;
  logic [31:0]          tick_now;
  logic [CW-1:0]        valid_total;
  logic [IW-1:0]        scan_idx;
  logic [4:0]           fire_cnt;
  msrt_pkg::out_t       pend;
  logic                 pend_has;
  logic signed [7:0]    req_rep;
  logic [31:0]          req_tmo;

  logic              accept;
  logic [IW+3:0]     id_ext;
  logic [IW-1:0]     id_idx;
  logic              id_ok;
  logic [31:0]       elapsed;
  logic              expire;
  logic signed [7:0] rep_dec;
  logic              retire;
  logic              report;
  logic              out_free;
  logic              eval_stall;
  logic [CW-1:0]     total_after;
  logic              out_load;
  msrt_pkg::out_t    out_next;

  function automatic logic [3:0] slot_field(logic [IW-1:0] i);
    logic [IW+3:0] e;
    e = (IW+4)'(i);
    return e[3:0];
  endfunction

  function automatic logic [4:0] cnt_field(logic [CW-1:0] c);
    logic [CW+4:0] e;
    e = (CW+5)'(c);
    return e[4:0];
  endfunction

  function automatic msrt_pkg::out_t mk_out(logic st, logic [3:0] sl, logic fi, logic re,
                                            logic [4:0] cnt, logic la);
    msrt_pkg::out_t r;
    r.status       = st;
    r.slot         = sl;
    r.fired        = fi;
    r.retired      = re;
    r.active_count = cnt;
    r.last         = la;
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign id_ext   = (IW+4)'(in_data.slot_id);
  assign id_idx   = id_ext[IW-1:0];
  assign id_ok    = (id_ext < (IW+4)'(NUM_SLOTS)) && slot_valid[id_idx];

  // Expiry check on the entry held in the registered read data
  assign elapsed     = tick_now - rd_data.start;
  assign expire      = slot_valid[scan_idx] && (elapsed >= rd_data.timeout);
  assign rep_dec     = (rd_data.repeats > 8'sd0) ? rd_data.repeats - 8'sd1 : rd_data.repeats;
  assign retire      = (rep_dec == 8'sd0);
  assign total_after = retire ? valid_total - CW'(1) : valid_total;
  assign report      = (fire_cnt < 5'(msrt_pkg::MAX_RESULTS));
  assign out_free    = !out_valid || out_ready;
  // A new reported firing pushes the held one out, which needs a free result register
  assign eval_stall  = expire && report && pend_has && !out_free;

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    out_load = 1'b0;
    out_next = pend;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.command == msrt_pkg::CMD_RESTART && id_ok) begin
            wr_en           = 1'b1;
            wr_addr         = id_idx;
            wr_data.start   = tick_now;
            wr_data.timeout = in_data.timeout_ticks;
            wr_data.repeats = in_data.repeat_count;
          end
          if (in_data.command == msrt_pkg::CMD_TICK) begin
            rd_en = 1'b1;
          end
        end
      end
      S_FIND: begin
        if (!slot_valid[scan_idx]) begin
          wr_en           = 1'b1;
          wr_addr         = scan_idx;
          wr_data.start   = tick_now;
          wr_data.timeout = req_tmo;
          wr_data.repeats = req_rep;
        end
      end
      S_EVAL: begin
        if (!eval_stall) begin
          if (expire) begin
            wr_en           = 1'b1;
            wr_addr         = scan_idx;
            wr_data.start   = tick_now;
            wr_data.timeout = rd_data.timeout;
            wr_data.repeats = rep_dec;
          end
          // Held firing goes out once a later one shows it was not the last
          if (expire && report && pend_has) begin
            out_load = 1'b1;
          end
          if (scan_idx != LAST_IDX) begin
            rd_en   = 1'b1;
            rd_addr = scan_idx + IW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_next.last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_valid  <= '0;
      tick_now    <= '0;
      valid_total <= '0;
      scan_idx    <= '0;
      fire_cnt    <= '0;
      pend_has    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_data  <= out_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.command)
              msrt_pkg::CMD_START: begin
                req_rep  <= in_data.repeat_count;
                req_tmo  <= in_data.timeout_ticks;
                scan_idx <= '0;
                state    <= S_FIND;
              end
              msrt_pkg::CMD_RESTART: begin
                pend  <= mk_out(!id_ok, in_data.slot_id, 1'b0, 1'b0,
                                cnt_field(valid_total), 1'b1);
                state <= S_FLUSH;
              end
              msrt_pkg::CMD_CANCEL: begin
                if (id_ok) begin
                  slot_valid[id_idx] <= 1'b0;
                  valid_total        <= valid_total - CW'(1);
                  pend <= mk_out(1'b0, in_data.slot_id, 1'b0, 1'b0,
                                 cnt_field(valid_total - CW'(1)), 1'b1);
                end else begin
                  pend <= mk_out(1'b1, in_data.slot_id, 1'b0, 1'b0,
                                 cnt_field(valid_total), 1'b1);
                end
                state <= S_FLUSH;
              end
              msrt_pkg::CMD_TICK: begin
                tick_now <= tick_now + 32'd1;
                scan_idx <= '0;
                fire_cnt <= '0;
                pend_has <= 1'b0;
                state    <= S_EVAL;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_FIND: begin
          if (!slot_valid[scan_idx]) begin
            slot_valid[scan_idx] <= 1'b1;
            valid_total          <= valid_total + CW'(1);
            pend  <= mk_out(1'b0, slot_field(scan_idx), 1'b0, 1'b0,
                            cnt_field(valid_total + CW'(1)), 1'b1);
            state <= S_FLUSH;
          end else if (scan_idx == LAST_IDX) begin
            pend  <= mk_out(1'b1, 4'd0, 1'b0, 1'b0, cnt_field(valid_total), 1'b1);
            state <= S_FLUSH;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_EVAL: begin
          if (!eval_stall) begin
            if (expire) begin
              if (retire) begin
                slot_valid[scan_idx] <= 1'b0;
                valid_total          <= total_after;
              end
              if (report) begin
                pend     <= mk_out(1'b0, slot_field(scan_idx), 1'b1, retire,
                                   cnt_field(total_after), 1'b0);
                pend_has <= 1'b1;
                fire_cnt <= fire_cnt + 5'd1;
              end
            end
            if (scan_idx == LAST_IDX) begin
              if (!pend_has && !(expire && report)) begin
                pend <= mk_out(1'b0, 4'd0, 1'b0, 1'b0, cnt_field(valid_total), 1'b1);
              end
              state <= S_FLUSH;
            end else begin
              scan_idx <= scan_idx + IW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for multi_slot_repeat_timer: drives start, restart, cancel and tick
// transfers with random gaps and back-pressure, and checks every result against a slot-table
// tracker kept here. Depends on msrt_pkg and the timer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msrt_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  // Tracks the slot table and the clock, and queues the results each command must produce.
  class slot_table_tracker;
    bit              live [NSLOT];
    bit [31:0]       started [NSLOT];
    bit [31:0]       period [NSLOT];
    bit signed [7:0] runs_left [NSLOT];
    bit [31:0]       now;
    bit [4:0]        live_total;
    out_t            pending_results [$];
    int              errors;

    function out_t make(bit status, bit [3:0] slot, bit fired, bit retired, bit last);
      out_t r;
      r.status       = status;
      r.slot         = slot;
      r.fired        = fired;
      r.retired      = retired;
      r.active_count = live_total;
      r.last         = last;
      return r;
    endfunction

    function void note_command(in_t cmd);
      out_t batch [$];
      int   idx;
      bit   retire;
      idx = -1;
      case (cmd_t'(cmd.command))
        CMD_START: begin
          for (int i = 0; i < NSLOT; i++)
            if (!live[i] && idx < 0) idx = i;
          if (idx < 0) begin
            pending_results.push_back(make(1'b1, 4'd0, 1'b0, 1'b0, 1'b1));
          end else begin
            live[idx]      = 1'b1;
            started[idx]   = now;
            period[idx]    = cmd.timeout_ticks;
            runs_left[idx] = cmd.repeat_count;
            live_total++;
            pending_results.push_back(make(1'b0, 4'(idx), 1'b0, 1'b0, 1'b1));
          end
        end
        CMD_RESTART, CMD_CANCEL: begin
          if (!live[cmd.slot_id]) begin
            pending_results.push_back(make(1'b1, cmd.slot_id, 1'b0, 1'b0, 1'b1));
          end else begin
            if (cmd_t'(cmd.command) == CMD_RESTART) begin
              started[cmd.slot_id]   = now;
              period[cmd.slot_id]    = cmd.timeout_ticks;
              runs_left[cmd.slot_id] = cmd.repeat_count;
            end else begin
              live[cmd.slot_id]      = 1'b0;
              started[cmd.slot_id]   = '0;
              period[cmd.slot_id]    = '0;
              runs_left[cmd.slot_id] = '0;
              live_total--;
            end
            pending_results.push_back(make(1'b0, cmd.slot_id, 1'b0, 1'b0, 1'b1));
          end
        end
        default: begin
          now++;
          for (int i = 0; i < NSLOT; i++) begin
            // elapsed time wraps modulo 2^32
            if (live[i] && (now - started[i]) >= period[i]) begin
              started[i] = now;
              if (runs_left[i] > 0) runs_left[i]--;
              retire = (runs_left[i] == 0);
              if (retire) begin
                live[i] = 1'b0;
                live_total--;
              end
              batch.push_back(make(1'b0, 4'(i), 1'b1, retire, 1'b0));
            end
          end
          if (batch.size() == 0) begin
            pending_results.push_back(make(1'b0, 4'd0, 1'b0, 1'b0, 1'b1));
          end else begin
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[j]) pending_results.push_back(batch[j]);
          end
        end
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display({"unexpected result: status=%0d slot=%0d fired=%0d retired=%0d",
                    " active=%0d last=%0d"},
                   got.status, got.slot, got.fired, got.retired, got.active_count, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.fired !== want.fired || got.retired !== want.retired ||
            got.active_count !== want.active_count || got.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display({"mismatch: want status=%0d slot=%0d fired=%0d retired=%0d",
                      " active=%0d last=%0d"},
                     want.status, want.slot, want.fired, want.retired, want.active_count,
                     want.last);
            $display({"          got  status=%0d slot=%0d fired=%0d retired=%0d",
                      " active=%0d last=%0d"},
                     got.status, got.slot, got.fired, got.retired, got.active_count,
                     got.last);
          end
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  slot_table_tracker sb = new();
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  multi_slot_repeat_timer #(.NUM_SLOTS(NSLOT)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check transfers, then pick next ready (long hold-off on request)
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  function automatic in_t make_item(cmd_t op, logic [3:0] id, logic signed [7:0] rep,
                                    logic [31:0] tmo);
    in_t it;
    it.command       = op;
    it.slot_id       = id;
    it.repeat_count  = rep;
    it.timeout_ticks = tmo;
    return it;
  endfunction

  // valid stays high across back-to-back items; this task only drops it for a gap
  task automatic send_item(in_t item);
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_command(item);
  endtask

  initial begin
    int          live_ids [$];
    int          r;
    cmd_t        op;
    logic [3:0]  id;
    logic signed [7:0] rep;
    logic [31:0] tmo;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty tick, bad restart/cancel, one-shot, forever, extremes, full table
    send_item(make_item(CMD_TICK, 4'd0, 8'sd0, 32'd0));
    send_item(make_item(CMD_RESTART, 4'd3, 8'sd5, 32'd7));
    send_item(make_item(CMD_CANCEL, 4'd15, -8'sd1, 32'hFFFF_FFFF));
    send_item(make_item(CMD_START, 4'd0, 8'sd0, 32'd0));
    send_item(make_item(CMD_TICK, 4'd0, 8'sd0, 32'd0));
    send_item(make_item(CMD_START, 4'd15, -8'sd128, 32'd0));
    send_item(make_item(CMD_START, 4'd0, 8'sd127, 32'hFFFF_FFFF));
    send_item(make_item(CMD_START, 4'd0, -8'sd1, 32'd2));
    send_item(make_item(CMD_START, 4'd0, 8'sd1, 32'd1));
    send_item(make_item(CMD_TICK, 4'd0, 8'sd0, 32'd0));
    send_item(make_item(CMD_TICK, 4'hF, 8'sh7F, 32'hFFFF_FFFF));
    send_item(make_item(CMD_RESTART, 4'd1, 8'sd3, 32'd1));
    send_item(make_item(CMD_CANCEL, 4'd0, 8'sd0, 32'd0));
    while (sb.live_total < NSLOT)
      send_item(make_item(CMD_START, 4'd0, 8'($urandom_range(0, 2)), 32'd0));
    send_item(make_item(CMD_START, 4'd0, 8'sd4, 32'd3));
    send_item(make_item(CMD_TICK, 4'd0, 8'sd0, 32'd0));

    for (int k = 0; k < 125; k++) begin
      if (k == 40) hold_req = 1'b1;
      if (k == 80) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
      end
      steady = (k >= 90 && k < 130);

      r = $urandom_range(99);
      if (r < 35)      op = CMD_TICK;
      else if (r < 60) op = CMD_START;
      else if (r < 78) op = CMD_RESTART;
      else             op = CMD_CANCEL;

      live_ids.delete();
      for (int i = 0; i < NSLOT; i++)
        if (sb.live[i]) live_ids.push_back(i);
      if (live_ids.size() > 0 && $urandom_range(9) < 8)
        id = 4'(live_ids[$urandom_range(live_ids.size() - 1)]);
      else
        id = 4'($urandom_range(15));

      case ($urandom_range(3))
        0:       rep = 8'($urandom_range(0, 3));
        1:       rep = -8'sd1;
        2:       rep = 8'($urandom());
        default: rep = 8'($urandom_range(1, 6));
      endcase
      // mostly short timeouts so slots fire; some full-range ones
      tmo = ($urandom_range(9) < 8) ? 32'($urandom_range(0, 5)) : 32'($urandom());

      send_item(make_item(op, id, rep, tmo));
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (3 * NSLOT) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/msrt_pkg.sv
rtl/core/multi_slot_repeat_timer.sv
sim/testbench.sv
